/* sv/positional_ordered_list_macros.svh */
// ----------------------------------------------------------------------------
// positional_ordered_list_macros.svh
// Assertion shorthands shared by the list engine RTL.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ORDERED_LIST_MACROS_SVH
`define POSITIONAL_ORDERED_LIST_MACROS_SVH

// property checked on every rising clock edge outside reset
`define POL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define POL_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* sv/pol_pkg.sv */
// ----------------------------------------------------------------------------
// pol_pkg
// Shared codes and port widths for the positional ordered list.
// ----------------------------------------------------------------------------
package pol_pkg;

  localparam int FUNC_W      = 3;
  localparam int HANDLE_IN_W = 16;
  localparam int POS_A_W     = 5;
  localparam int POS_B_W     = 4;
  localparam int LEN_W       = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD_FRONT = 3'd0,
    FUNC_ADD_END   = 3'd1,
    FUNC_INSERT_AT = 3'd2,
    FUNC_DEL_FRONT = 3'd3,
    FUNC_DEL_END   = 3'd4,
    FUNC_DEL_AT    = 3'd5,
    FUNC_READ      = 3'd6,
    FUNC_SWAP      = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_SWAP
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC
  } state_e;

endpackage

/* sv/positional_ordered_list.sv */
// ----------------------------------------------------------------------------
// positional_ordered_list
// Ordered handle list on a chain of shifting slots: add, insert, delete,
// read and swap by position, one word of result per command.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake               Payload
// command   in   start_i & !busy_o       func_i, handle_i, pos_a_i, pos_b_i
// result    out  done_o (one cycle)      value_o, ok_o, length_o
//
// Add, insert and delete are accepted, then updated in EXEC: every slot at or
// past the position shifts from its neighbor at once. An in-range read or
// swap first passes FETCH, which registers the selected slot words off the
// OR bus; a refused read or swap skips the fetch. The result strobe comes in
// the cycle after the update, and a new command is accepted in that same
// cycle. Reset clears state, length count and result strobe; slot words are
// not cleared and no slot at or past the length is ever read out. The
// receiver cannot stall; busy_o is high only while a command is in work.
// ----------------------------------------------------------------------------
`include "positional_ordered_list_macros.svh"

module positional_ordered_list
  import pol_pkg::*;
#(
  parameter int CAPACITY     = 16,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [FUNC_W-1:0]      func_i,
  input  logic [HANDLE_IN_W-1:0] handle_i,
  input  logic [POS_A_W-1:0]     pos_a_i,
  input  logic [POS_B_W-1:0]     pos_b_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [HANDLE_IN_W-1:0] value_o,
  output logic                   ok_o,
  output logic [LEN_W-1:0]       length_o
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_A_W) ? CW : POS_A_W;
  localparam int SW   = (HANDLE_WIDTH < HANDLE_IN_W) ? HANDLE_WIDTH : HANDLE_IN_W;
  localparam logic [CMPW-1:0] CapX = CMPW'(CAPACITY);

  state_e        state_q, state_d;
  cell_op_e      op_q, op_d, cell_op;
  logic          ok_q, ok_d;
  logic          rd_q, rd_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] pb_q, pb_d;
  logic [SW-1:0] handle_q, handle_d;
  logic [SW-1:0] val_a_q, val_a_d;
  logic [SW-1:0] val_b_q, val_b_d;
  logic [CW-1:0] count_q, count_d;
  logic          done_q, done_d;
  logic          res_ok_q, res_ok_d;
  logic [HANDLE_IN_W-1:0] value_q, value_d;
  logic [LEN_W-1:0]       len_q, len_d;

  logic [CMPW-1:0] cnt_x, pa_x, pb_x, cntm1_x;
  logic            full, empty;

  logic [SW-1:0] cell_data [CAPACITY];
  logic [SW-1:0] sel_a     [CAPACITY];
  logic [SW-1:0] sel_b     [CAPACITY];
  logic [SW-1:0] bus_a, bus_b;

  // ---- slot chain ----
  assign cell_op = (state_q == ST_EXEC) ? op_q : CELL_HOLD;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [SW-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = cell_data[i];
    end else begin : g_left
      assign left_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_right
      assign right_w = cell_data[i+1];
    end

    pol_cell #(
      .IDX (i),
      .CW  (CW),
      .SW  (SW)
    ) u_cell (
      .clk_i    (clk_i),
      .op_i     (cell_op),
      .pos_a_i  (pos_q),
      .pos_b_i  (pb_q),
      .handle_i (handle_q),
      .val_a_i  (val_a_q),
      .val_b_i  (val_b_q),
      .left_i   (left_w),
      .right_i  (right_w),
      .data_o   (cell_data[i]),
      .sel_a_o  (sel_a[i]),
      .sel_b_o  (sel_b[i])
    );
  end

  // at most one slot matches each position, so OR acts as the mux
  always_comb begin
    bus_a = '0;
    bus_b = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      bus_a = bus_a | sel_a[k];
      bus_b = bus_b | sel_b[k];
    end
  end

  // ---- control ----
  assign cnt_x   = CMPW'(count_q);
  assign cntm1_x = cnt_x - CMPW'(1);
  assign pa_x    = CMPW'(pos_a_i);
  assign pb_x    = CMPW'(pos_b_i);
  assign full    = (cnt_x == CapX);
  assign empty   = (count_q == '0);

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    ok_d     = ok_q;
    rd_d     = rd_q;
    pos_d    = pos_q;
    pb_d     = pb_q;
    handle_d = handle_q;
    val_a_d  = val_a_q;
    val_b_d  = val_b_q;
    count_d  = count_q;
    done_d   = 1'b0;
    res_ok_d = res_ok_q;
    value_d  = value_q;
    len_d    = len_q;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          handle_d = handle_i[SW-1:0];
          pb_d     = pb_x[CW-1:0];
          rd_d     = 1'b0;
          pos_d    = pa_x[CW-1:0];
          op_d     = CELL_HOLD;
          ok_d     = 1'b0;
          case (func_e'(func_i))
            FUNC_ADD_FRONT: begin
              ok_d = !full; pos_d = '0; op_d = CELL_INSERT;
            end
            FUNC_ADD_END: begin
              ok_d = !full; pos_d = count_q; op_d = CELL_INSERT;
            end
            FUNC_INSERT_AT: begin
              ok_d = !full && (pa_x <= cnt_x); op_d = CELL_INSERT;
            end
            FUNC_DEL_FRONT: begin
              ok_d = !empty; pos_d = '0; op_d = CELL_DELETE;
            end
            FUNC_DEL_END: begin
              ok_d = !empty; pos_d = cntm1_x[CW-1:0]; op_d = CELL_DELETE;
            end
            FUNC_DEL_AT: begin
              ok_d = (pa_x < cnt_x); op_d = CELL_DELETE;
            end
            FUNC_READ: begin
              ok_d = (pa_x < cnt_x); rd_d = 1'b1;
            end
            FUNC_SWAP: begin
              ok_d = (pa_x < cnt_x) && (pb_x < cnt_x); op_d = CELL_SWAP;
            end
            default: ok_d = 1'b0;
          endcase
          if (!ok_d) op_d = CELL_HOLD;
          // read and swap need the slot words gathered first
          if (ok_d && (rd_d || op_d == CELL_SWAP)) state_d = ST_FETCH;
          else state_d = ST_EXEC;
        end
      end
      ST_FETCH: begin
        val_a_d = bus_a;
        val_b_d = bus_b;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (op_q == CELL_INSERT) count_d = count_q + CW'(1);
        else if (op_q == CELL_DELETE) count_d = count_q - CW'(1);
        done_d   = 1'b1;
        res_ok_d = ok_q;
        value_d  = (rd_q && ok_q) ? HANDLE_IN_W'(val_a_q) : '0;
        len_d    = LEN_W'(CMPW'(count_d));
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    ok_q     <= ok_d;
    rd_q     <= rd_d;
    pos_q    <= pos_d;
    pb_q     <= pb_d;
    handle_q <= handle_d;
    val_a_q  <= val_a_d;
    val_b_q  <= val_b_d;
    res_ok_q <= res_ok_d;
    value_q  <= value_d;
    len_q    <= len_d;
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign value_o  = value_q;
  assign ok_o     = res_ok_q;
  assign length_o = len_q;

  // ---- checks ----
  `POL_NEVER(a_count_bound, CMPW'(count_q) > CapX, "list length past capacity")
  `POL_ASSERT(a_exec_done, state_q == ST_EXEC |=> done_q, "update without result")
  `POL_ASSERT(a_done_idle, done_q |-> state_q == ST_IDLE, "result while busy")
  `POL_ASSERT(a_refused_len, done_q && !res_ok_q |-> count_q == $past(count_q),
              "refused command changed length")

endmodule

/* sv/pol_cell.sv */
// ----------------------------------------------------------------------------
// pol_cell
// One list slot: holds a word and shifts it to/from its neighbors.
// ----------------------------------------------------------------------------
module pol_cell
  import pol_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 5,
  parameter int SW  = 16
) (
  input  logic          clk_i,
  input  cell_op_e      op_i,
  input  logic [CW-1:0] pos_a_i,
  input  logic [CW-1:0] pos_b_i,
  input  logic [SW-1:0] handle_i,
  input  logic [SW-1:0] val_a_i,
  input  logic [SW-1:0] val_b_i,
  input  logic [SW-1:0] left_i,
  input  logic [SW-1:0] right_i,
  output logic [SW-1:0] data_o,
  output logic [SW-1:0] sel_a_o,
  output logic [SW-1:0] sel_b_o
);

  localparam logic [CW-1:0] MyIdx = CW'(IDX);

  logic [SW-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (op_i)
      CELL_INSERT: begin
        if (MyIdx == pos_a_i) data_d = handle_i;
        else if (MyIdx > pos_a_i) data_d = left_i;
      end
      CELL_DELETE: begin
        if (MyIdx >= pos_a_i) data_d = right_i;
      end
      CELL_SWAP: begin
        // equal positions: val_b equals this cell's own word
        if (MyIdx == pos_a_i) data_d = val_b_i;
        else if (MyIdx == pos_b_i) data_d = val_a_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign sel_a_o = (MyIdx == pos_a_i) ? data_q : '0;
  assign sel_b_o = (MyIdx == pos_b_i) ? data_q : '0;

endmodule

/* test/positional_ordered_list_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_ordered_list_tb
// Self-checking bench for the list engine. A queue of commands (directed
// corner cases, then random bursts that fill, drain or mix the list) feeds a
// clocked driver with random gaps. A shadow copy of the list predicts every
// result word and the monitor checks each strobed word against it.
// ----------------------------------------------------------------------------
module positional_ordered_list_tb;
  import pol_pkg::*;

  localparam int LIST_CAP   = 16;
  localparam int HANDLE_W   = 16;
  localparam int MAX_GAP    = 12;
  localparam int RAND_CMDS  = 1520;
  localparam int PRINT_CAP  = 40;

  typedef struct {
    func_e                  op;
    logic [HANDLE_IN_W-1:0] handle;
    logic [POS_A_W-1:0]     pos_a;
    logic [POS_B_W-1:0]     pos_b;
    int unsigned            gap;
  } list_cmd_t;

  typedef struct {
    logic [HANDLE_IN_W-1:0] value;
    logic                   ok;
    logic [LEN_W-1:0]       length;
  } list_word_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start_i;
  logic [FUNC_W-1:0]      func_i;
  logic [HANDLE_IN_W-1:0] handle_i;
  logic [POS_A_W-1:0]     pos_a_i;
  logic [POS_B_W-1:0]     pos_b_i;
  logic                   busy_o;
  logic                   done_o;
  logic [HANDLE_IN_W-1:0] value_o;
  logic                   ok_o;
  logic [LEN_W-1:0]       length_o;

  list_cmd_t   pending_cmds[$];
  list_word_t  awaited_words[$];
  list_cmd_t   cur_cmd;
  int unsigned idle_cnt;
  int unsigned err_cnt;

  // shadow list
  logic [HANDLE_W-1:0] shadow_slots [LIST_CAP];
  int unsigned         shadow_len;

  // stimulus-side length tracking and gap policy
  int unsigned gen_len;
  int unsigned gap_max;

  positional_ordered_list #(
    .CAPACITY    (LIST_CAP),
    .HANDLE_WIDTH(HANDLE_W)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .func_i  (func_i),
    .handle_i(handle_i),
    .pos_a_i (pos_a_i),
    .pos_b_i (pos_b_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .value_o (value_o),
    .ok_o    (ok_o),
    .length_o(length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    if (err_cnt < PRINT_CAP) begin
      $display("%0t ns: mismatch: %s", $realtime, msg);
    end
    err_cnt++;
  endtask

  function automatic logic shadow_put(input int unsigned pos, input logic [HANDLE_W-1:0] h);
    if (shadow_len >= LIST_CAP || pos > shadow_len) return 1'b0;
    for (int i = shadow_len; i > pos; i--) shadow_slots[i] = shadow_slots[i-1];
    shadow_slots[pos] = h;
    shadow_len++;
    return 1'b1;
  endfunction

  function automatic logic shadow_take(input int unsigned pos);
    if (pos >= shadow_len) return 1'b0;
    for (int i = pos; i + 1 < shadow_len; i++) shadow_slots[i] = shadow_slots[i+1];
    shadow_len--;
    return 1'b1;
  endfunction

  // Applies one command to the shadow list and returns the word it yields.
  function automatic list_word_t apply_list_op(input list_cmd_t c);
    list_word_t          w;
    logic [HANDLE_W-1:0] tmp;
    w.value = '0;
    w.ok    = 1'b0;
    case (c.op)
      FUNC_ADD_FRONT: w.ok = shadow_put(0, c.handle);
      FUNC_ADD_END:   w.ok = shadow_put(shadow_len, c.handle);
      FUNC_INSERT_AT: w.ok = shadow_put(c.pos_a, c.handle);
      FUNC_DEL_FRONT: w.ok = shadow_take(0);
      FUNC_DEL_END:   w.ok = (shadow_len > 0) ? shadow_take(shadow_len - 1) : 1'b0;
      FUNC_DEL_AT:    w.ok = shadow_take(c.pos_a);
      FUNC_READ: begin
        if (c.pos_a < shadow_len) begin
          w.value = shadow_slots[c.pos_a];
          w.ok    = 1'b1;
        end
      end
      default: begin
        if (c.pos_a < shadow_len && c.pos_b < shadow_len) begin
          tmp                   = shadow_slots[c.pos_a];
          shadow_slots[c.pos_a] = shadow_slots[c.pos_b];
          shadow_slots[c.pos_b] = tmp;
          w.ok                  = 1'b1;
        end
      end
    endcase
    w.length = shadow_len[LEN_W-1:0];
    return w;
  endfunction

  task automatic queue_cmd(input func_e op, input logic [HANDLE_IN_W-1:0] h,
                           input logic [POS_A_W-1:0] pa, input logic [POS_B_W-1:0] pb);
    list_cmd_t c;
    c.op     = op;
    c.handle = h;
    c.pos_a  = pa;
    c.pos_b  = pb;
    c.gap    = $urandom_range(0, gap_max);
    pending_cmds.push_back(c);
    case (op)
      FUNC_ADD_FRONT, FUNC_ADD_END: if (gen_len < LIST_CAP) gen_len++;
      FUNC_INSERT_AT: if (gen_len < LIST_CAP && pa <= gen_len) gen_len++;
      FUNC_DEL_FRONT, FUNC_DEL_END: if (gen_len > 0) gen_len--;
      FUNC_DEL_AT: if (pa < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  // mostly in range, now and then anywhere the port allows
  function automatic int unsigned pick_pos(input int unsigned upper, input int unsigned port_max);
    if ($urandom_range(0, 4) == 0 || upper == 0) return $urandom_range(0, port_max);
    return $urandom_range(0, upper - 1);
  endfunction

  function automatic logic [HANDLE_IN_W-1:0] pick_handle();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return HANDLE_IN_W'($urandom);
    endcase
  endfunction

  task automatic queue_random_burst(input int unsigned mode, input int unsigned n);
    func_e       op;
    int unsigned upper;
    for (int k = 0; k < n; k++) begin
      if (mode == 0 && $urandom_range(0, 9) < 7) begin
        op = func_e'($urandom_range(0, 2));
      end else if (mode == 1 && $urandom_range(0, 9) < 7) begin
        op = func_e'(3 + $urandom_range(0, 2));
      end else begin
        op = func_e'($urandom_range(0, 7));
      end
      upper = (op == FUNC_INSERT_AT) ? gen_len + 1 : gen_len;
      queue_cmd(op, pick_handle(), POS_A_W'(pick_pos(upper, 31)),
                POS_B_W'(pick_pos(gen_len, 15)));
    end
  endtask

  // driver: one command word held on the ports until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i  <= 1'b0;
      func_i   <= FUNC_READ;
      handle_i <= '0;
      pos_a_i  <= '0;
      pos_b_i  <= '0;
      idle_cnt <= 0;
    end else begin : drive
      logic fire;
      fire = start_i && !busy_o;
      if (fire) awaited_words.push_back(apply_list_op(cur_cmd));
      if (fire || !start_i) begin
        if (pending_cmds.size() != 0 && idle_cnt >= pending_cmds[0].gap) begin
          cur_cmd  = pending_cmds.pop_front();
          start_i  <= 1'b1;
          func_i   <= cur_cmd.op;
          handle_i <= cur_cmd.handle;
          pos_a_i  <= cur_cmd.pos_a;
          pos_b_i  <= cur_cmd.pos_b;
          idle_cnt <= 0;
        end else begin
          start_i <= 1'b0;
          if (pending_cmds.size() != 0) idle_cnt <= idle_cnt + 1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin : check
      list_word_t w;
      if (awaited_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word value=%h ok=%b length=%0d",
                                  value_o, ok_o, length_o));
      end else begin
        w = awaited_words.pop_front();
        if (value_o !== w.value)
          report_mismatch($sformatf("value %h, expected %h", value_o, w.value));
        if (ok_o !== w.ok)
          report_mismatch($sformatf("ok %b, expected %b", ok_o, w.ok));
        if (length_o !== w.length)
          report_mismatch($sformatf("length %0d, expected %0d", length_o, w.length));
      end
    end
  end

  initial begin
    #3_000_000;
    $display("positional_ordered_list regression: fail");
    $finish;
  end

  initial begin
    int unsigned queued;
    err_cnt    = 0;
    shadow_len = 0;
    gen_len    = 0;
    gap_max    = MAX_GAP;
    rst_ni     = 1'b0;
    foreach (shadow_slots[i]) shadow_slots[i] = '0;

    // empty list: every delete, read and swap is refused, as is a far insert
    queue_cmd(FUNC_READ,      '0, 0, 0);
    queue_cmd(FUNC_DEL_FRONT, '0, 0, 0);
    queue_cmd(FUNC_DEL_END,   '0, 0, 0);
    queue_cmd(FUNC_DEL_AT,    '0, 0, 0);
    queue_cmd(FUNC_SWAP,      '0, 0, 0);
    queue_cmd(FUNC_INSERT_AT, 16'h1234, 1, 0);
    // build up, insert at 0 and at the current length
    queue_cmd(FUNC_INSERT_AT, 16'h5a5a, 0, 0);
    queue_cmd(FUNC_ADD_FRONT, 16'hffff, 0, 0);
    queue_cmd(FUNC_ADD_END,   16'h0000, 0, 0);
    queue_cmd(FUNC_INSERT_AT, 16'ha5a5, 3, 0);
    while (gen_len < LIST_CAP) queue_cmd(FUNC_ADD_END, pick_handle(), 0, 0);
    // full list refuses an add at the front and an insert
    queue_cmd(FUNC_ADD_FRONT, 16'hbeef, 0, 0);
    queue_cmd(FUNC_INSERT_AT, 16'hbeef, 0, 0);
    queue_cmd(FUNC_READ,      '0, 15, 0);
    queue_cmd(FUNC_READ,      '0, 16, 0);
    queue_cmd(FUNC_SWAP,      '0, 3, 4);
    queue_cmd(FUNC_SWAP,      '0, 5, 5);
    queue_cmd(FUNC_SWAP,      '0, 16, 2);
    queue_cmd(FUNC_DEL_AT,    '0, 15, 0);
    queue_cmd(FUNC_DEL_AT,    '0, 16, 0);
    queue_cmd(FUNC_DEL_FRONT, '0, 0, 0);
    queue_cmd(FUNC_DEL_END,   '0, 0, 0);

    // random bursts: fill, drain or mixed, some with back-to-back words
    queued = 0;
    while (queued < RAND_CMDS) begin : burst
      int unsigned n;
      n       = $urandom_range(8, 40);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
      queue_random_burst($urandom_range(0, 2), n);
      queued += n;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || start_i || awaited_words.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("positional_ordered_list regression: pass");
    end else begin
      $display("positional_ordered_list regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/pol_pkg.sv
sv/pol_cell.sv
sv/positional_ordered_list.sv
test/positional_ordered_list_tb.sv
